// ===== sv/tkpt_pkg.sv =====
// Package for the three-key pose tween: widths, register and request codes, shared types.
// No dependencies; every other file in sv/ depends on it.
package tkpt_pkg;

   localparam int TIME_WIDTH      = 24;
   localparam int T_FRAC_BITS     = 16;
   localparam int SCALE_FRAC      = 12;
   localparam int FIELD_WIDTH     = 16;
   localparam int KEY_WIDTH       = 4 * FIELD_WIDTH;
   localparam int SIZE_WIDTH      = 2 * FIELD_WIDTH;
   localparam int OPND_WIDTH      = FIELD_WIDTH + 2;
   localparam int PROD_WIDTH      = 2 * OPND_WIDTH;
   localparam int CSR_DATA_WIDTH  = KEY_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int REQ_TYPE_WIDTH  = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_KEY  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIDDLE_KEY = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_KEY    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RISE_TIME  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TIME  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_TIME = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASE_SIZE  = 3'd6;

   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_START = 2'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_INIT  = 2'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_NOP   = 2'd3;

   typedef logic [KEY_WIDTH-1:0]      key_type;
   typedef logic [TIME_WIDTH-1:0]     time_type;
   typedef logic [T_FRAC_BITS-1:0]    frac_type;
   typedef logic [FIELD_WIDTH-1:0]    field_type;
   typedef logic [SIZE_WIDTH-1:0]     size_type;
   typedef logic [REQ_TYPE_WIDTH-1:0] req_code_type;

   // keys to blend and the blend fraction; a == b with t == 0 shows one key
   typedef struct packed {
      key_type  key_a;
      key_type  key_b;
      frac_type t;
   } pose_job_type;

endpackage

// ===== sv/tkpt_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on tkpt_pkg for field widths.
interface tkpt_req_if;
   logic                  valid;
   logic                  ready;
   tkpt_pkg::req_code_type req_type;
   tkpt_pkg::time_type     delta_time;

   modport source (output valid, output req_type, output delta_time, input ready);
   modport sink   (input valid, input req_type, input delta_time, output ready);
endinterface

interface tkpt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [tkpt_pkg::FIELD_WIDTH-1:0] pos_x;
   logic signed [tkpt_pkg::FIELD_WIDTH-1:0] pos_y;
   tkpt_pkg::field_type            size_w;
   tkpt_pkg::field_type            size_h;
   logic                           running;
   logic                           done_res;

   modport source (output valid, output pos_x, output pos_y, output size_w, output size_h,
                   output running, output done_res, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input size_w, input size_h,
                   input running, input done_res, output ready);
endinterface

// ===== sv/tkpt_div.sv =====
// Restoring divider, one quotient bit per cycle: quot = floor(num * 2^T_FRAC_BITS / den).
// Needs num < den. Depends on tkpt_pkg.
module tkpt_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tkpt_pkg::time_type num,
   input  tkpt_pkg::time_type den,
   output logic               busy,
   output tkpt_pkg::frac_type quot
);
   import tkpt_pkg::*;

   localparam int CNT_WIDTH = $clog2(T_FRAC_BITS + 1);

   logic [TIME_WIDTH:0]  rem_ff, rem_in;
   time_type             den_ff, den_in;
   frac_type             quot_ff, quot_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [TIME_WIDTH:0]  shifted;
   logic [TIME_WIDTH:0]  trial;
   logic                 fits;

   always_comb begin
      // remainder stays below den, so the doubled value fits
      shifted = {rem_ff[TIME_WIDTH-1:0], 1'b0};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         quot_in = '0;
         cnt_in  = CNT_WIDTH'(T_FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial : shifted;
         quot_in = {quot_ff[T_FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// ===== sv/tkpt_pose.sv =====
// Pose unit: one shared 18x18 multiplier walks the four lanes (x, y, w, h) in turn,
// doing the blend and, for w and h, the size scaling. Holds the pose last shown.
// Depends on tkpt_pkg.
module tkpt_pose (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tkpt_pkg::pose_job_type job,
   input  tkpt_pkg::size_type     base_size,
   output logic                   busy,
   output logic [3:0][tkpt_pkg::FIELD_WIDTH-1:0] pose
);
   import tkpt_pkg::*;

   localparam logic [1:0] PH_LERP = 2'd0;
   localparam logic [1:0] PH_ADD  = 2'd1;
   localparam logic [1:0] PH_SIZE = 2'd2;
   localparam logic [1:0] PH_SAT  = 2'd3;

   logic [1:0]                   lane_ff, lane_in;
   logic [1:0]                   phase_ff, phase_in;
   logic                         busy_ff, busy_in;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in;
   field_type                    val_ff, val_in;
   logic [3:0][FIELD_WIDTH-1:0]  pose_ff, pose_in;

   field_type                    a_fld, b_fld, base_fld, sat_val;
   logic signed [OPND_WIDTH-1:0] a_ext, b_ext, op_a, op_b, lerp_sum;
   logic signed [PROD_WIDTH-1:0] prod_shr;

   always_comb begin
      a_fld    = job.key_a[lane_ff*FIELD_WIDTH +: FIELD_WIDTH];
      b_fld    = job.key_b[lane_ff*FIELD_WIDTH +: FIELD_WIDTH];
      base_fld = base_size[lane_ff[0]*FIELD_WIDTH +: FIELD_WIDTH];
      // position lanes are signed, scale lanes unsigned
      if (lane_ff[1]) begin
         a_ext = {2'b00, a_fld};
         b_ext = {2'b00, b_fld};
      end else begin
         a_ext = {{2{a_fld[FIELD_WIDTH-1]}}, a_fld};
         b_ext = {{2{b_fld[FIELD_WIDTH-1]}}, b_fld};
      end
      if (phase_ff == PH_SIZE) begin
         op_a = {2'b00, val_ff};
         op_b = {2'b00, base_fld};
      end else begin
         op_a = b_ext - a_ext;
         op_b = {{(OPND_WIDTH-T_FRAC_BITS){1'b0}}, job.t};
      end
      // arithmetic shift gives the floor of the scaled product
      prod_shr = prod_ff >>> T_FRAC_BITS;
      lerp_sum = a_ext + prod_shr[OPND_WIDTH-1:0];
      sat_val  = (|prod_ff[PROD_WIDTH-1:SCALE_FRAC+FIELD_WIDTH]) ? '1
                 : prod_ff[SCALE_FRAC +: FIELD_WIDTH];

      lane_in  = lane_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      prod_in  = prod_ff;
      val_in   = val_ff;
      pose_in  = pose_ff;
      if (start) begin
         lane_in  = '0;
         phase_in = PH_LERP;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         unique case (phase_ff)
            PH_LERP, PH_SIZE: begin
               prod_in  = op_a * op_b;
               phase_in = phase_ff + 1'b1;
            end
            PH_ADD: begin
               val_in = lerp_sum[FIELD_WIDTH-1:0];
               if (lane_ff[1]) begin
                  phase_in = PH_SIZE;
               end else begin
                  pose_in[lane_ff] = lerp_sum[FIELD_WIDTH-1:0];
                  lane_in          = lane_ff + 1'b1;
                  phase_in         = PH_LERP;
               end
            end
            default: begin
               pose_in[lane_ff] = sat_val;
               lane_in          = lane_ff + 1'b1;
               phase_in         = PH_LERP;
               if (lane_ff == 2'd3) begin
                  busy_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff  <= '0;
         phase_ff <= PH_LERP;
         busy_ff  <= 1'b0;
         pose_ff  <= '0;
      end else begin
         lane_ff  <= lane_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         pose_ff  <= pose_in;
      end
      prod_ff <= prod_in;
      val_ff  <= val_in;
   end

   assign busy = busy_ff;
   assign pose = pose_ff;

endmodule

// ===== sv/three_key_pose_tween.sv =====
// Three-key pose tween. One request beat at a time; ready is low while a beat is in work.
// Tick in a blend segment runs the divider and then the pose unit; a tick on the hold or idle pose
// runs only the pose unit; start, initialise and no-op go straight to the reply.
// The 16-step divider and the shared pose multiplier set how long a tick takes.
// Synchronous active-high reset clears registers, flags, elapsed time and shown pose to zero.
module three_key_pose_tween (
   input  logic                clock,
   input  logic                reset,
   tkpt_req_if.sink            req_bus,
   tkpt_rsp_if.source          rsp_bus,
   input  logic                csr_we,
   input  logic [tkpt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tkpt_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import tkpt_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEG   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_POSE  = 3'd3;
   localparam logic [2:0] S_REPLY = 3'd4;

   // key selectors
   localparam logic [1:0] KEY_START  = 2'd0;
   localparam logic [1:0] KEY_MIDDLE = 2'd1;
   localparam logic [1:0] KEY_END    = 2'd2;

   // configuration registers
   key_type  start_key_ff, middle_key_ff, end_key_ff;
   time_type rise_ff, hold_ff, total_ff;
   size_type base_ff;

   // sequencer and animation state
   logic [2:0] state_ff, state_in;
   time_type   elapsed_ff, elapsed_in;
   logic       active_ff, active_in;
   logic       finished_ff, finished_in;
   logic [1:0] sel_a_ff, sel_a_in, sel_b_ff, sel_b_in;
   frac_type   t_ff, t_in;

   // response register, frees the pose unit while the beat waits
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0][FIELD_WIDTH-1:0] rsp_pose_ff, rsp_pose_in;
   logic       rsp_run_ff, rsp_run_in, rsp_done_ff, rsp_done_in;

   logic         req_fire;
   logic [TIME_WIDTH:0] elapsed_sum, hold_end;
   time_type     div_num, div_den;
   logic         div_start, div_busy;
   frac_type     div_quot;
   logic         pose_start, pose_busy;
   pose_job_type job;
   logic [3:0][FIELD_WIDTH-1:0] pose;

   function automatic key_type pick_key(input logic [1:0] sel, input key_type ks,
                                        input key_type km, input key_type ke);
      key_type k;
      unique case (sel)
         KEY_START:  k = ks;
         KEY_MIDDLE: k = km;
         default:    k = ke;
      endcase
      return k;
   endfunction

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_key_ff  <= '0;
         middle_key_ff <= '0;
         end_key_ff    <= '0;
         rise_ff       <= '0;
         hold_ff       <= '0;
         total_ff      <= '0;
         base_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_KEY:  start_key_ff  <= csr_wdata;
            CSR_MIDDLE_KEY: middle_key_ff <= csr_wdata;
            CSR_END_KEY:    end_key_ff    <= csr_wdata;
            CSR_RISE_TIME:  rise_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_HOLD_TIME:  hold_ff       <= csr_wdata[TIME_WIDTH-1:0];
            CSR_TOTAL_TIME: total_ff      <= csr_wdata[TIME_WIDTH-1:0];
            CSR_BASE_SIZE:  base_ff       <= csr_wdata[SIZE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign job.key_a = pick_key(sel_a_ff, start_key_ff, middle_key_ff, end_key_ff);
   assign job.key_b = pick_key(sel_b_ff, start_key_ff, middle_key_ff, end_key_ff);
   assign job.t     = t_ff;

   always_comb begin
      elapsed_sum = {1'b0, elapsed_ff} + {1'b0, req_bus.delta_time};
      hold_end    = {1'b0, rise_ff} + {1'b0, hold_ff};

      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      active_in    = active_ff;
      finished_in  = finished_ff;
      sel_a_in     = sel_a_ff;
      sel_b_in     = sel_b_ff;
      t_in         = t_ff;
      div_start    = 1'b0;
      div_num      = elapsed_ff;
      div_den      = rise_ff;
      pose_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pose_in  = rsp_pose_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_REPLY;
               unique case (req_bus.req_type)
                  REQ_TICK: begin
                     if (!active_ff) begin
                        // idle tick shows a whole key: blend of a key with itself
                        sel_a_in   = finished_ff ? KEY_END : KEY_START;
                        sel_b_in   = finished_ff ? KEY_END : KEY_START;
                        t_in       = '0;
                        pose_start = 1'b1;
                        state_in   = S_POSE;
                     end else if (elapsed_ff < total_ff) begin
                        // saturating add of frame time
                        elapsed_in = elapsed_sum[TIME_WIDTH] ? '1
                                     : elapsed_sum[TIME_WIDTH-1:0];
                        state_in   = S_SEG;
                     end
                     // running past total: nothing changes
                  end
                  REQ_START: active_in = 1'b1;
                  REQ_INIT: begin
                     elapsed_in  = '0;
                     active_in   = 1'b0;
                     finished_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_SEG: begin
            // segment tests in order on the new elapsed time
            state_in = S_REPLY;
            if (elapsed_ff < rise_ff) begin
               sel_a_in  = KEY_START;
               sel_b_in  = KEY_MIDDLE;
               div_num   = elapsed_ff;
               div_den   = rise_ff;
               div_start = 1'b1;
               state_in  = S_DIV;
            end else if ({1'b0, elapsed_ff} < hold_end) begin
               sel_a_in   = KEY_MIDDLE;
               sel_b_in   = KEY_MIDDLE;
               t_in       = '0;
               pose_start = 1'b1;
               state_in   = S_POSE;
            end else if (elapsed_ff < total_ff) begin
               // hold_end <= elapsed here, so it fits the time width
               sel_a_in  = KEY_MIDDLE;
               sel_b_in  = KEY_END;
               div_num   = elapsed_ff - hold_end[TIME_WIDTH-1:0];
               div_den   = total_ff - hold_end[TIME_WIDTH-1:0];
               div_start = 1'b1;
               state_in  = S_DIV;
            end
            // finishing tick that misses every segment repeats the last pose
            if (elapsed_ff >= total_ff) begin
               active_in   = 1'b0;
               finished_in = 1'b1;
            end
         end
         S_DIV: begin
            if (!div_busy) begin
               t_in       = div_quot;
               pose_start = 1'b1;
               state_in   = S_POSE;
            end
         end
         S_POSE: begin
            if (!pose_busy) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pose_in  = pose;
               rsp_run_in   = active_ff;
               rsp_done_in  = finished_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elapsed_ff   <= '0;
         active_ff    <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_a_ff     <= KEY_START;
         sel_b_ff     <= KEY_START;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         active_ff    <= active_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_a_ff     <= sel_a_in;
         sel_b_ff     <= sel_b_in;
      end
      t_ff        <= t_in;
      rsp_pose_ff <= rsp_pose_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_done_ff <= rsp_done_in;
   end

   tkpt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   tkpt_pose u_pose (
      .clock     (clock),
      .reset     (reset),
      .start     (pose_start),
      .job       (job),
      .base_size (base_ff),
      .busy      (pose_busy),
      .pose      (pose)
   );

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.pos_x    = rsp_pose_ff[0];
   assign rsp_bus.pos_y    = rsp_pose_ff[1];
   assign rsp_bus.size_w   = rsp_pose_ff[2];
   assign rsp_bus.size_h   = rsp_pose_ff[3];
   assign rsp_bus.running  = rsp_run_ff;
   assign rsp_bus.done_res = rsp_done_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for three_key_pose_tween: directed plan, then randomised phases.
// Depends on tkpt_pkg, the tkpt_req_if/tkpt_rsp_if interfaces and the block itself.
module testbench;
   import tkpt_pkg::*;

   // one response beat as the scoreboard holds it
   typedef struct packed {
      field_type pos_x;
      field_type pos_y;
      field_type size_w;
      field_type size_h;
      logic      running;
      logic      done_res;
   } pose_beat_type;

   // directed row: request plus an optional hand-worked response
   typedef struct packed {
      req_code_type  code;
      time_type      dt;
      logic          pinned;
      pose_beat_type pose;
   } plan_row_type;

   typedef enum {SET_MAX, SET_MIN, SET_SKEWED, SET_PLAIN} setting_kind_type;

   localparam int WATCHDOG_LIMIT = 1500;
   localparam int SETTLE_CYCLES  = 40;
   localparam int TAIL_CYCLES    = 50;
   localparam int PHASES         = 10;
   localparam int PHASE_BEATS    = 110;
   localparam int TICK_CAP       = 20;
   localparam int KEYED_ROW      = 5;
   localparam longint unsigned TIME_MAX = (64'd1 << TIME_WIDTH) - 1;

   // hand-worked poses; all-zero registers first, then the directed key set
   localparam pose_beat_type NO_PIN     = '0;
   localparam pose_beat_type ZERO_IDLE  = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0};
   localparam pose_beat_type ZERO_RUN   = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0};
   localparam pose_beat_type START_IDLE = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0FFF, 1'b0, 1'b0};
   localparam pose_beat_type START_RUN  = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0FFF, 1'b1, 1'b0};
   localparam pose_beat_type MIDDLE_RUN = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0200, 1'b1, 1'b0};
   localparam pose_beat_type END_DONE   = '{16'h0010, 16'hFFF0, 16'hFFFF, 16'h0100, 1'b0, 1'b1};

   // rows before KEYED_ROW run on reset registers, the rest on the directed key set
   localparam plan_row_type PLAN [0:23] = '{
      '{REQ_TICK,  24'h000000, 1'b1, ZERO_IDLE},   // idle tick straight after reset
      '{REQ_NOP,   24'hFFFFFF, 1'b1, ZERO_IDLE},
      '{REQ_START, 24'h000000, 1'b1, ZERO_RUN},
      '{REQ_TICK,  24'hFFFFFF, 1'b1, ZERO_RUN},    // total zero: running past the end
      '{REQ_INIT,  24'h000000, 1'b1, ZERO_IDLE},
      '{REQ_TICK,  24'h000000, 1'b1, START_IDLE},  // idle, not finished: start pose
      '{REQ_START, 24'h000000, 1'b1, START_RUN},
      '{REQ_TICK,  24'h000000, 1'b1, START_RUN},   // zero fraction on the rise
      '{REQ_TICK,  24'h004000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'h00C000, 1'b1, MIDDLE_RUN},  // lands exactly on rise time
      '{REQ_TICK,  24'h004000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'h002000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'h002000, 1'b0, NO_PIN},      // exactly at the end of the hold
      '{REQ_TICK,  24'h00A000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'hFFFFFF, 1'b0, NO_PIN},      // elapsed saturates, finishing tick
      '{REQ_TICK,  24'h000005, 1'b1, END_DONE},    // idle and finished: end pose
      '{REQ_START, 24'h000000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'h000100, 1'b0, NO_PIN},      // restart without init stays parked
      '{REQ_INIT,  24'h000000, 1'b0, NO_PIN},
      '{REQ_NOP,   24'h000000, 1'b0, NO_PIN},
      '{REQ_START, 24'h000000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'h03FFFF, 1'b0, NO_PIN},      // finishes in one go, repeats last pose
      '{REQ_INIT,  24'h000000, 1'b0, NO_PIN},
      '{REQ_TICK,  24'h000000, 1'b1, START_IDLE}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   tkpt_req_if req_bus ();
   tkpt_rsp_if rsp_bus ();

   three_key_pose_tween i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers
   key_type  key_start, key_mid, key_end;
   time_type t_rise, t_hold, t_total;
   size_type base_wh;

   // predictor copy of the animation state
   time_type  anim_elapsed;
   logic      anim_active, anim_finished;
   field_type shown [4];

   pose_beat_type pose_due [$];   // responses still owed, oldest first

   // pinned response travels with the request beat
   logic          pin_on;
   pose_beat_type pin_value;

   logic req_gaps_on, rsp_gaps_on;
   int   stall_left      = 0;
   int   quiet_cycles    = 0;
   int   mismatches      = 0;
   int   beats_sent      = 0;
   int   beats_checked   = 0;
   int   settings_loaded = 0;
   int   anims_completed = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int key_signed(key_type k, int slot);
      return int'($signed(k[slot*FIELD_WIDTH +: FIELD_WIDTH]));
   endfunction

   function automatic int key_unsigned(key_type k, int slot);
      return int'(k[slot*FIELD_WIDTH +: FIELD_WIDTH]);
   endfunction

   // a + floor((b - a) * t / 2^16); the arithmetic shift gives the floor
   function automatic int blend(int a, int b, longint t);
      longint p;
      p = longint'(b - a) * t;
      return a + int'(p >>> T_FRAC_BITS);
   endfunction

   // default size times a Q4.12 scale, clamped to 16 bits
   function automatic field_type sized(int slot, int scale);
      longint unsigned prod;
      prod = (longint'(base_wh[slot*FIELD_WIDTH +: FIELD_WIDTH]) * longint'(scale)) >> SCALE_FRAC;
      return (prod > 64'hFFFF) ? 16'hFFFF : prod[FIELD_WIDTH-1:0];
   endfunction

   // blend of two keys; a single key is shown as (k, k, 0)
   function automatic void show_pose(key_type ka, key_type kb, longint t);
      shown[0] = field_type'(blend(key_signed(ka, 0), key_signed(kb, 0), t));
      shown[1] = field_type'(blend(key_signed(ka, 1), key_signed(kb, 1), t));
      shown[2] = sized(0, blend(key_unsigned(ka, 2), key_unsigned(kb, 2), t));
      shown[3] = sized(1, blend(key_unsigned(ka, 3), key_unsigned(kb, 3), t));
   endfunction

   function automatic pose_beat_type advance_pose(req_code_type code, time_type dt);
      longint unsigned acc, hold_end;
      case (code)
         REQ_TICK: begin
            if (!anim_active) begin
               show_pose(anim_finished ? key_end : key_start,
                         anim_finished ? key_end : key_start, 0);
            end else if (anim_elapsed < t_total) begin
               acc = longint'(anim_elapsed) + longint'(dt);
               if (acc > TIME_MAX) acc = TIME_MAX;
               anim_elapsed = time_type'(acc);
               hold_end = longint'(t_rise) + longint'(t_hold);
               // segments tried in order; a finishing tick matching none keeps the old pose
               if (acc < t_rise) begin
                  show_pose(key_start, key_mid, longint'((acc << T_FRAC_BITS) / t_rise));
               end else if (acc < hold_end) begin
                  show_pose(key_mid, key_mid, 0);
               end else if (acc < t_total) begin
                  show_pose(key_mid, key_end,
                            longint'(((acc - hold_end) << T_FRAC_BITS) / (t_total - hold_end)));
               end
               if (acc >= t_total) begin
                  anim_active   = 1'b0;
                  anim_finished = 1'b1;
                  anims_completed++;
               end
            end
            // active with elapsed already past total: nothing moves
         end
         REQ_START: anim_active = 1'b1;
         REQ_INIT: begin
            anim_elapsed  = '0;
            anim_active   = 1'b0;
            anim_finished = 1'b0;
         end
         default: ;
      endcase
      return '{shown[0], shown[1], shown[2], shown[3], anim_active, anim_finished};
   endfunction

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // both channels sampled at the rising edge, request side first
   always @(posedge clock) begin : watch
      pose_beat_type want, got;
      logic          quiet;
      if (!reset) begin
         quiet = 1'b1;
         if (req_bus.valid && req_bus.ready) begin
            want = advance_pose(req_bus.req_type, req_bus.delta_time);
            pose_due.push_back(pin_on ? pin_value : want);
            quiet = 1'b0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.pos_x, rsp_bus.pos_y, rsp_bus.size_w, rsp_bus.size_h,
                    rsp_bus.running, rsp_bus.done_res};
            if (pose_due.size() == 0) begin
               $display("%0t: response beat with none expected, got %h", $time, got);
               mismatches++;
            end else begin
               want = pose_due.pop_front();
               check_field("pos_x",    want.pos_x,    got.pos_x);
               check_field("pos_y",    want.pos_y,    got.pos_y);
               check_field("size_w",   want.size_w,   got.size_w);
               check_field("size_h",   want.size_h,   got.size_h);
               check_field("running",  16'(want.running),  16'(got.running));
               check_field("done_res", 16'(want.done_res), 16'(got.done_res));
               beats_checked++;
            end
            quiet = 1'b0;
         end
         quiet_cycles = quiet ? quiet_cycles + 1 : 0;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles, %0d responses owed",
                     $time, quiet_cycles, pose_due.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // mostly back to back, some short gaps, the odd long one
   function automatic int pick_gap(logic on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(rsp_gaps_on);
      end
   end

   // entered and left at a falling edge; valid stays up when the next beat follows at once
   task automatic send_beat(input req_code_type code, input time_type dt,
                            input logic pinned, input pose_beat_type pin_pose);
      int gap;
      gap = pick_gap(req_gaps_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= code;
      req_bus.delta_time <= dt;
      pin_on             <= pinned;
      pin_value          <= pin_pose;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      beats_sent++;
   endtask

   // sender holds off until every owed response is back, then lets the block go quiet
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pose_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                          input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // only called with the block idle
   task automatic load_config(input key_type ks, input key_type km, input key_type ke,
                              input time_type tr, input time_type th, input time_type tt,
                              input size_type bs);
      put_csr(CSR_START_KEY,  ks);
      put_csr(CSR_MIDDLE_KEY, km);
      put_csr(CSR_END_KEY,    ke);
      put_csr(CSR_RISE_TIME,  CSR_DATA_WIDTH'(tr));
      put_csr(CSR_HOLD_TIME,  CSR_DATA_WIDTH'(th));
      put_csr(CSR_TOTAL_TIME, CSR_DATA_WIDTH'(tt));
      put_csr(CSR_BASE_SIZE,  CSR_DATA_WIDTH'(bs));
      csr_we    <= 1'b0;
      key_start = ks;
      key_mid   = km;
      key_end   = ke;
      t_rise    = tr;
      t_hold    = th;
      t_total   = tt;
      base_wh   = bs;
      settings_loaded++;
   endtask

   task automatic choose_setting(input setting_kind_type kind);
      key_type  k [3];
      time_type r, h, t;
      size_type b;
      for (int i = 0; i < 3; i++) k[i] = {$urandom, $urandom};
      b = $urandom;
      if ($urandom_range(0, 3) == 0) b[15:0]  = 16'hFFFF;
      if ($urandom_range(0, 3) == 0) b[31:16] = 16'hFFFF;
      case (kind)
         SET_MAX: begin
            k[0] = '1;
            k[1] = '1;
            k[2] = '1;
            r    = '1;
            h    = '1;
            t    = '1;
            b    = '1;
         end
         SET_MIN: begin
            r = '0;
            h = '0;
            t = time_type'($urandom_range(0, 1));
         end
         SET_SKEWED: begin
            // unrelated times: hold end may lie past total, rise past both
            r = time_type'($urandom_range(0, 'h40000));
            h = time_type'($urandom_range(0, 'h40000));
            t = time_type'($urandom_range(0, 'h40000));
         end
         default: begin
            r = ($urandom_range(0, 7) == 0) ? '0 : time_type'($urandom_range(1, 'h20000));
            h = ($urandom_range(0, 3) == 0) ? '0 : time_type'($urandom_range(1, 'h20000));
            t = r + h + time_type'($urandom_range(1, 'h20000));
         end
      endcase
      load_config(k[0], k[1], k[2], r, h, t, b);
   endtask

   // frame times sized to the current animation, with zero, full-range and maximum mixed in
   function automatic time_type pick_delta();
      int r;
      longint unsigned span;
      span = (t_total == 0) ? 1 : longint'(t_total);
      r = $urandom_range(0, 99);
      if (r < 65) return time_type'($urandom_range(0, int'(span / 4) + 1));
      if (r < 75) return '0;
      if (r < 90) return time_type'($urandom);
      if (r < 95) return '1;
      return time_type'($urandom_range(1, 3));
   endfunction

   // mostly init/start/ticks-to-the-end runs with random content, the rest noise
   task automatic run_phase(input int quota);
      int first, n;
      first = beats_sent;
      while (beats_sent - first < quota) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 4) != 0) send_beat(REQ_INIT, pick_delta(), 1'b0, NO_PIN);
            if ($urandom_range(0, 5) == 0) send_beat(REQ_TICK, pick_delta(), 1'b0, NO_PIN);
            send_beat(REQ_START, time_type'($urandom), 1'b0, NO_PIN);
            n = 0;
            while (anim_active && n < TICK_CAP) begin
               send_beat(REQ_TICK, pick_delta(), 1'b0, NO_PIN);
               n++;
            end
            repeat ($urandom_range(0, 2)) send_beat(REQ_TICK, pick_delta(), 1'b0, NO_PIN);
            if ($urandom_range(0, 7) == 0)
               send_beat(REQ_NOP, time_type'($urandom), 1'b0, NO_PIN);
         end else begin
            send_beat(req_code_type'($urandom_range(0, 3)), time_type'($urandom), 1'b0, NO_PIN);
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      setting_kind_type kind;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_NOP;
      req_bus.delta_time = '0;
      rsp_bus.ready      = 1'b0;
      pin_on             = 1'b0;
      pin_value          = NO_PIN;
      req_gaps_on        = 1'b1;
      rsp_gaps_on        = 1'b1;
      // predictor matches the cleared block
      key_start     = '0;
      key_mid       = '0;
      key_end       = '0;
      t_rise        = '0;
      t_hold        = '0;
      t_total       = '0;
      base_wh       = '0;
      anim_elapsed  = '0;
      anim_active   = 1'b0;
      anim_finished = 1'b0;
      for (int i = 0; i < 4; i++) shown[i] = '0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed plan; the key set goes in once the reset-register rows have drained
      for (int i = 0; i < $size(PLAN); i++) begin
         if (i == KEYED_ROW) begin
            settle_block();
            load_config(64'hFFFF_1000_7FFF_8000, 64'h2000_0000_8000_7FFF,
                        64'h1000_1000_FFF0_0010, 24'h010000, 24'h008000, 24'h030000,
                        32'h0100_FFFF);
         end
         send_beat(PLAN[i].code, PLAN[i].dt, PLAN[i].pinned, PLAN[i].pose);
      end

      // random phases: extremes first, then a mix; some phases run without gaps
      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         case (p)
            0:       kind = SET_MAX;
            1:       kind = SET_MIN;
            2:       kind = SET_SKEWED;
            default: kind = ($urandom_range(0, 3) == 0) ? SET_SKEWED : SET_PLAIN;
         endcase
         req_gaps_on = (p % 4 != 3);
         rsp_gaps_on = (p % 3 != 2);
         choose_setting(kind);
         run_phase(PHASE_BEATS);
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d request beats and %0d checked responses over %0d register settings.",
               beats_sent, beats_checked, settings_loaded);
      $display("%0d animations ran through to their end time; %0d mismatches.",
               anims_completed, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tkpt_pkg.sv
sv/tkpt_if.sv
sv/tkpt_div.sv
sv/tkpt_pose.sv
sv/three_key_pose_tween.sv
verif/testbench.sv
